// File: design/plb_pkg.sv
// Shared types and constants for the positional list buffer.
package plb_pkg;

   localparam int WORD_W = 32;
   localparam int KIND_W = 3;
   localparam int POS_W  = 5;
   localparam int CNT_W  = 5;
   localparam int STAT_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_INS_FRONT  = 3'd0,
      KIND_INS_BACK   = 3'd1,
      KIND_PEEK_FIRST = 3'd2,
      KIND_PEEK_LAST  = 3'd3,
      KIND_DEL_FRONT  = 3'd4,
      KIND_DEL_BACK   = 3'd5,
      KIND_DEL_AT     = 3'd6,
      KIND_INS_AT     = 3'd7
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [WORD_W-1:0]  value;
   } cell_ctrl_type;

endpackage

// File: design/plb_cell.sv
// One storage cell of the list chain, shifting with its neighbors.
module plb_cell #(
   parameter int DEPTH = 16,
   parameter int INDEX = 0,
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                        clock,
   input  plb_pkg::cell_ctrl_type      ctrl,
   input  logic [IW-1:0]               idx,
   input  logic [plb_pkg::WORD_W-1:0]  left_data,
   input  logic [plb_pkg::WORD_W-1:0]  right_data,
   output logic [plb_pkg::WORD_W-1:0]  data,
   output logic [plb_pkg::WORD_W-1:0]  tap
);
   import plb_pkg::*;

   localparam logic [IW-1:0] MyIdx = IW'(INDEX);

   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctrl.op)
         CELL_INSERT: begin
            if (MyIdx > idx) begin
               data_in = left_data;
            end else if (MyIdx == idx) begin
               data_in = ctrl.value;
            end
         end
         CELL_REMOVE: begin
            if (MyIdx >= idx) begin
               data_in = right_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign tap  = (MyIdx == idx) ? data_ff : '0;

endmodule

// File: design/positional_list_buffer_top.sv
// Top level of the positional list buffer: request decode, cell chain and result register.
// The buffer holds up to DEPTH signed words in order in a row of cells. Every request
// (insert at front, back or a 1-based position; delete at front, back or a position;
// peek at first or last) yields one response carrying the peeked or removed word, the
// count after the request and a status. A request is accepted every cycle while the
// response register is empty or being drained, since the whole cell row shifts by one
// place together and the selected word is read through an AND-OR across the cells. The
// response is registered in the cycle after acceptance. Failed requests (empty, full,
// bad position) change nothing and return zero. No clearing pass follows reset; only
// the count and the response valid flag are cleared.
module positional_list_buffer_top #(
   parameter int DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [plb_pkg::KIND_W-1:0]  req_kind,
   input  logic signed [plb_pkg::WORD_W-1:0] req_value,
   input  logic [plb_pkg::POS_W-1:0]   req_position,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [plb_pkg::WORD_W-1:0] rsp_result_value,
   output logic [plb_pkg::CNT_W-1:0]   rsp_count,
   output logic [plb_pkg::STAT_W-1:0]  rsp_status
);
   import plb_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OW = $clog2(DEPTH + 1);
   localparam int CW = ((OW > POS_W) ? OW : POS_W) + 1;

   logic [OW-1:0]     occ_ff;
   logic [OW-1:0]     occ_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [WORD_W-1:0] rsp_value_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   status_type        rsp_status_ff;

   logic              accept;
   logic              full;
   logic              empty;
   logic [CW-1:0]     pos_w;
   logic [CW-1:0]     occ_w;
   cell_op_type       op_dec;
   logic [IW-1:0]     idx;
   status_type        st;
   logic              rd_en;
   logic [WORD_W-1:0] rd_word;
   cell_ctrl_type     ctrl;

   logic [WORD_W-1:0] cell_data [DEPTH];
   logic [WORD_W-1:0] cell_tap  [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (occ_ff == OW'(DEPTH));
   assign empty     = (occ_ff == '0);
   assign pos_w     = CW'(req_position);
   assign occ_w     = CW'(occ_ff);

   always_comb begin
      op_dec = CELL_HOLD;
      idx    = '0;
      st     = STATUS_OK;
      rd_en  = 1'b0;
      unique case (kind_type'(req_kind))
         KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
            if (full) begin
               st = STATUS_FULL;
            end else if (kind_type'(req_kind) == KIND_INS_FRONT) begin
               op_dec = CELL_INSERT;
            end else if (kind_type'(req_kind) == KIND_INS_BACK) begin
               op_dec = CELL_INSERT;
               idx    = IW'(occ_ff);
            end else if (pos_w == '0 || pos_w > occ_w + 1'b1) begin
               st = STATUS_RANGE;
            end else begin
               op_dec = CELL_INSERT;
               idx    = IW'(pos_w - 1'b1);
            end
         end
         KIND_PEEK_FIRST, KIND_PEEK_LAST: begin
            if (empty) begin
               st = STATUS_EMPTY;
            end else begin
               rd_en = 1'b1;
               if (kind_type'(req_kind) == KIND_PEEK_LAST) begin
                  idx = IW'(occ_ff - 1'b1);
               end
            end
         end
         KIND_DEL_FRONT, KIND_DEL_BACK: begin
            if (empty) begin
               st = STATUS_EMPTY;
            end else begin
               rd_en  = 1'b1;
               op_dec = CELL_REMOVE;
               if (kind_type'(req_kind) == KIND_DEL_BACK) begin
                  idx = IW'(occ_ff - 1'b1);
               end
            end
         end
         KIND_DEL_AT: begin
            if (empty) begin
               st = STATUS_EMPTY;
            end else if (pos_w == '0 || pos_w > occ_w) begin
               st = STATUS_RANGE;
            end else begin
               rd_en  = 1'b1;
               op_dec = CELL_REMOVE;
               idx    = IW'(pos_w - 1'b1);
            end
         end
         default: begin
            op_dec = CELL_HOLD;
         end
      endcase
   end

   always_comb begin
      ctrl.op    = accept ? op_dec : CELL_HOLD;
      ctrl.value = req_value;
   end

   always_comb begin
      occ_in = occ_ff;
      if (ctrl.op == CELL_INSERT) begin
         occ_in = occ_ff + 1'b1;
      end else if (ctrl.op == CELL_REMOVE) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] left_data;
      logic [WORD_W-1:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end
      plb_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .idx        (idx),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .tap        (cell_tap[i])
      );
   end

   always_comb begin
      rd_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_word = rd_word | cell_tap[i];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff  <= rd_en ? rd_word : '0;
         rsp_count_ff  <= CNT_W'(occ_in);
         rsp_status_ff <= st;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_count        = rsp_count_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// File: design/plb_checker.sv
// Port-level assertions for the positional list buffer and their bind.
module plb_checker #(
   parameter int DEPTH = 16
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [plb_pkg::WORD_W-1:0] rsp_result_value,
   input logic [plb_pkg::CNT_W-1:0]   rsp_count,
   input logic [plb_pkg::STAT_W-1:0]  rsp_status
);
   import plb_pkg::*;

   localparam logic [CNT_W-1:0] FullCount = CNT_W'(DEPTH);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   a_accept_responds: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("Accepted transaction produced no response.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
      && $stable(rsp_count) && $stable(rsp_status))
      else $error("Stalled response changed.");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_result_value == '0)
      else $error("Failed transaction returned a nonzero word.");

   a_status_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != STATUS_EMPTY || rsp_count == '0)
      && (rsp_status != STATUS_FULL || rsp_count == FullCount))
      else $error("Status disagrees with the reported count.");

endmodule

bind positional_list_buffer_top plb_checker #(.DEPTH(DEPTH)) u_plb_checker (.*);

// File: dv/testbench.sv
// Self-checking testbench for the positional list buffer: directed and random requests.
`timescale 1ns / 1ps

module testbench;
   import plb_pkg::*;

   localparam int LIST_DEPTH  = 16;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 295;

   class list_scoreboard;
      typedef struct {
         logic [WORD_W-1:0] value;
         logic [CNT_W-1:0]  count;
         status_type        status;
      } outcome_type;

      logic [WORD_W-1:0] words [LIST_DEPTH];
      int unsigned       fill = 0;
      outcome_type       outcomes [$];
      int unsigned       failures = 0;

      function void open_slot(int unsigned idx, logic [WORD_W-1:0] w);
         for (int unsigned i = fill; i > idx; i--) words[i] = words[i-1];
         words[idx] = w;
         fill++;
      endfunction

      function logic [WORD_W-1:0] close_slot(int unsigned idx);
         logic [WORD_W-1:0] w;
         w = words[idx];
         for (int unsigned i = idx; i + 1 < fill; i++) words[i] = words[i+1];
         fill--;
         return w;
      endfunction

      function int unsigned pending();
         return outcomes.size();
      endfunction

      function void note_request(kind_type kind, logic [WORD_W-1:0] value,
                                 logic [POS_W-1:0] position);
         outcome_type o;
         o.value  = '0;
         o.status = STATUS_OK;
         case (kind)
            KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
               if (fill >= LIST_DEPTH) begin
                  o.status = STATUS_FULL;
               end else if (kind == KIND_INS_FRONT) begin
                  open_slot(0, value);
               end else if (kind == KIND_INS_BACK) begin
                  open_slot(fill, value);
               end else if (position < 1 || position > fill + 1) begin
                  o.status = STATUS_RANGE;
               end else begin
                  open_slot(position - 1, value);
               end
            end
            KIND_PEEK_FIRST, KIND_PEEK_LAST: begin
               if (fill == 0) o.status = STATUS_EMPTY;
               else o.value = (kind == KIND_PEEK_FIRST) ? words[0] : words[fill-1];
            end
            KIND_DEL_FRONT, KIND_DEL_BACK: begin
               if (fill == 0) o.status = STATUS_EMPTY;
               else o.value = close_slot(kind == KIND_DEL_FRONT ? 0 : fill - 1);
            end
            default: begin
               if (fill == 0) begin
                  o.status = STATUS_EMPTY;
               end else if (position < 1 || position > fill) begin
                  o.status = STATUS_RANGE;
               end else begin
                  o.value = close_slot(position - 1);
               end
            end
         endcase
         o.count = fill[CNT_W-1:0];
         outcomes.push_back(o);
      endfunction

      function void check_response(logic [WORD_W-1:0] value, logic [CNT_W-1:0] count,
                                   logic [STAT_W-1:0] status);
         outcome_type o;
         if (outcomes.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
            return;
         end
         o = outcomes.pop_front();
         if (value !== o.value) begin
            $error("result_value: expected %0d, actual %0d", $signed(o.value), $signed(value));
            failures++;
         end
         if (count !== o.count) begin
            $error("count: expected %0d, actual %0d", o.count, count);
            failures++;
         end
         if (status !== o.status) begin
            $error("status: expected %0d, actual %0d", o.status, status);
            failures++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [KIND_W-1:0]        req_kind = '0;
   logic signed [WORD_W-1:0] req_value = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [WORD_W-1:0] rsp_result_value;
   logic [CNT_W-1:0]         rsp_count;
   logic [STAT_W-1:0]        rsp_status;

   int unsigned    send_idle_pct = 0;
   int unsigned    recv_stall_pct = 0;
   int unsigned    quiet_cycles = 0;
   bit             growing = 1'b1;
   list_scoreboard board = new();

   positional_list_buffer_top #(.DEPTH(LIST_DEPTH)) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_value(req_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_value(rsp_result_value),
      .rsp_count(rsp_count),
      .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         board.note_request(kind_type'(req_kind), req_value, req_position);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_response(rsp_result_value, rsp_count, rsp_status);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("positional_list_buffer_top regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Leaves the caller at a falling edge after any sender idle cycles.
   task automatic next_slot();
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic drive_request(input kind_type kind, input logic [WORD_W-1:0] value,
                                input logic [POS_W-1:0] position);
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_value    <= value;
      req_position <= position;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic directed(input kind_type kind, input logic [WORD_W-1:0] value,
                           input logic [POS_W-1:0] position);
      next_slot();
      drive_request(kind, value, position);
   endtask

   task automatic random_request();
      int unsigned       roll;
      int unsigned       occ;
      kind_type          kind;
      logic [WORD_W-1:0] value;
      logic [POS_W-1:0]  position;
      next_slot();
      occ = board.fill;
      if (occ == LIST_DEPTH) growing = 1'b0;
      else if (occ == 0) growing = 1'b1;
      else if ($urandom_range(99) < 3) growing = ~growing;
      value = $urandom();
      if ($urandom_range(7) == 0) begin
         case ($urandom_range(3))
            0: value = 32'h8000_0000;
            1: value = 32'h7fff_ffff;
            2: value = 32'h0000_0000;
            default: value = 32'hffff_ffff;
         endcase
      end
      roll = $urandom_range(99);
      if (roll < 8) begin
         kind     = kind_type'($urandom_range(7));
         position = POS_W'($urandom_range(31));
      end else begin
         roll = $urandom_range(99);
         if (roll < 10) begin
            kind     = $urandom_range(1) ? KIND_PEEK_FIRST : KIND_PEEK_LAST;
            position = POS_W'($urandom_range(31));
         end else if (roll < (growing ? 75 : 35)) begin
            case ($urandom_range(2))
               0: kind = KIND_INS_FRONT;
               1: kind = KIND_INS_BACK;
               default: kind = KIND_INS_AT;
            endcase
            position = POS_W'($urandom_range(1, (occ < LIST_DEPTH) ? occ + 1 : LIST_DEPTH));
         end else begin
            case ($urandom_range(2))
               0: kind = KIND_DEL_FRONT;
               1: kind = KIND_DEL_BACK;
               default: kind = KIND_DEL_AT;
            endcase
            position = POS_W'($urandom_range(1, (occ > 0) ? occ : 1));
         end
      end
      drive_request(kind, value, position);
   endtask

   task automatic wait_drained();
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned send_pct [4];
      int unsigned recv_pct [4];
      send_pct = '{0, 88, 0, 15};
      recv_pct = '{0, 0, 88, 15};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed(KIND_PEEK_FIRST, 32'h0, 5'd0);
      directed(KIND_PEEK_LAST, 32'h0, 5'd31);
      directed(KIND_DEL_FRONT, 32'h0, 5'd0);
      directed(KIND_DEL_BACK, 32'h0, 5'd0);
      directed(KIND_DEL_AT, 32'h0, 5'd1);
      directed(KIND_INS_AT, 32'h1, 5'd0);
      directed(KIND_INS_AT, 32'h2, 5'd2);
      directed(KIND_INS_AT, 32'h8000_0000, 5'd1);
      directed(KIND_INS_BACK, 32'h7fff_ffff, 5'd0);
      directed(KIND_INS_FRONT, 32'hffff_ffff, 5'd0);
      directed(KIND_INS_AT, 32'h0, 5'd4);
      directed(KIND_INS_AT, 32'h5a5a_a5a5, 5'd2);
      for (int i = 5; i < LIST_DEPTH; i++) directed(KIND_INS_BACK, $urandom(), 5'd0);
      directed(KIND_INS_FRONT, 32'h1234_5678, 5'd0);
      directed(KIND_INS_AT, 32'h1234_5678, 5'd0);
      directed(KIND_DEL_AT, 32'h0, 5'd0);
      directed(KIND_DEL_AT, 32'h0, 5'd17);
      directed(KIND_DEL_AT, 32'h0, 5'd16);
      directed(KIND_PEEK_FIRST, 32'h0, 5'd0);
      directed(KIND_PEEK_LAST, 32'h0, 5'd0);
      directed(KIND_DEL_FRONT, 32'h0, 5'd0);
      directed(KIND_DEL_BACK, 32'h0, 5'd0);
      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = send_pct[p];
         recv_stall_pct = recv_pct[p];
         for (int n = 0; n < PHASE_ITEMS; n++) random_request();
         @(negedge clock);
         req_valid <= 1'b0;
         wait_drained();
      end

      repeat (5) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("positional_list_buffer_top regression: pass");
      end else begin
         $display("positional_list_buffer_top regression: fail");
      end
      $finish;
   end

endmodule
